### rtl/dq_pkg.sv
// shared constants, types and codes for the double-ended queue
package dq_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 64;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int SUM_W     = CNT_W + 1;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 64;
  localparam int OCC_W    = 5;

  localparam logic [ACTION_W-1:0] ACT_NONE       = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_REVERSE    = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd6;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_LOAD
  } dq_state_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [VALUE_W-1:0]  value;
  } dq_in_t;

  typedef struct packed {
    dq_status_t         status;
    logic [VALUE_W-1:0] front_value;
    logic [VALUE_W-1:0] back_value;
    logic [OCC_W-1:0]   occupancy;
    logic               is_empty;
    logic               is_full;
  } dq_out_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } dq_cmd_t;

endpackage

### rtl/dq_ram.sv
// generic ram, one write port and two registered read ports
module dq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### rtl/dq_ctrl.sv
// controller state machine sequencing update, ring read and result load
module dq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output dq_pkg::dq_cmd_t cmd
);

  dq_pkg::dq_state_t state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              load_ok;

  assign load_ok = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dq_pkg::S_IDLE: if (in_valid) state_nxt = dq_pkg::S_EXEC;
      dq_pkg::S_EXEC: state_nxt = dq_pkg::S_READ;
      dq_pkg::S_READ: state_nxt = dq_pkg::S_LOAD;
      dq_pkg::S_LOAD: if (load_ok) state_nxt = dq_pkg::S_IDLE;
      default:        state_nxt = dq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state_r == dq_pkg::S_IDLE);
    cmd.capture = in_valid && (state_r == dq_pkg::S_IDLE);
    cmd.exec    = (state_r == dq_pkg::S_EXEC);
    cmd.load    = (state_r == dq_pkg::S_LOAD) && load_ok;
    out_valid   = out_valid_r;
    priority if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/dq_dp.sv
// datapath: head, count, reversed flag, ring store and result register
module dq_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  dq_pkg::dq_cmd_t cmd,
  input  dq_pkg::dq_in_t  in_data,
  output dq_pkg::dq_out_t out_data
);

  localparam logic [dq_pkg::IDX_W-1:0] LAST_IDX = dq_pkg::IDX_W'(dq_pkg::DEPTH - 1);
  localparam logic [dq_pkg::CNT_W-1:0] FULL_CNT = dq_pkg::CNT_W'(dq_pkg::DEPTH);
  localparam logic [dq_pkg::SUM_W-1:0] DEPTH_S  = dq_pkg::SUM_W'(dq_pkg::DEPTH);

  logic [dq_pkg::ACTION_W-1:0]  act_r;
  logic [dq_pkg::WORD_BITS-1:0] val_r;
  logic [dq_pkg::IDX_W-1:0]     head_r, head_nxt;
  logic [dq_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                         rev_r, rev_nxt;
  dq_pkg::dq_status_t           status_r, status_nxt;
  dq_pkg::dq_out_t              out_r, out_nxt;

  logic [dq_pkg::IDX_W-1:0]     head_dec, head_inc, tail_ins, tail_idx;
  logic [dq_pkg::SUM_W-1:0]     ins_sum, last_sum;
  logic                         empty, full, to_low;
  logic                         we;
  logic [dq_pkg::IDX_W-1:0]     waddr;
  logic [dq_pkg::WORD_BITS-1:0] rd_lo, rd_hi;
  logic [dq_pkg::VALUE_W-1:0]   lo_ext, hi_ext;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == FULL_CNT);
  assign head_dec = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;

  // slot just past the high end, valid while not full
  assign ins_sum  = dq_pkg::SUM_W'(head_r) + dq_pkg::SUM_W'(cnt_r);
  assign tail_ins = (ins_sum >= DEPTH_S) ? dq_pkg::IDX_W'(ins_sum - DEPTH_S)
                                         : dq_pkg::IDX_W'(ins_sum);

  // slot at the high end, valid while not empty
  assign last_sum = ins_sum - 1'b1;
  assign tail_idx = empty ? head_r :
                    (last_sum >= DEPTH_S) ? dq_pkg::IDX_W'(last_sum - DEPTH_S)
                                          : dq_pkg::IDX_W'(last_sum);

  always_comb begin
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    rev_nxt    = rev_r;
    status_nxt = dq_pkg::ST_OK;
    we         = 1'b0;
    waddr      = tail_ins;
    to_low     = 1'b0;
    unique case (act_r)
      dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_BACK: begin
        if (full) begin
          status_nxt = dq_pkg::ST_FULL;
        end else begin
          to_low  = (act_r == dq_pkg::ACT_PUSH_FRONT) != rev_r;
          we      = cmd.exec;
          cnt_nxt = cnt_r + 1'b1;
          if (to_low) begin
            head_nxt = head_dec;
            waddr    = head_dec;
          end
        end
      end
      dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_POP_BACK: begin
        if (empty) begin
          status_nxt = dq_pkg::ST_EMPTY;
        end else begin
          to_low  = (act_r == dq_pkg::ACT_POP_FRONT) != rev_r;
          cnt_nxt = cnt_r - 1'b1;
          if (to_low) begin
            head_nxt = head_inc;
          end
        end
      end
      dq_pkg::ACT_REVERSE: begin
        if (empty) begin
          status_nxt = dq_pkg::ST_EMPTY;
        end else begin
          rev_nxt = !rev_r;
        end
      end
      dq_pkg::ACT_CLEAR: begin
        head_nxt = '0;
        cnt_nxt  = '0;
        rev_nxt  = 1'b0;
      end
      default: ;
    endcase
  end

  dq_ram #(
    .WIDTH (dq_pkg::WORD_BITS),
    .DEPTH (dq_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (val_r),
    .raddr_a (head_r),
    .raddr_b (tail_idx),
    .rdata_a (rd_lo),
    .rdata_b (rd_hi)
  );

  assign lo_ext = empty ? '0 : dq_pkg::VALUE_W'(rd_lo);
  assign hi_ext = empty ? '0 : dq_pkg::VALUE_W'(rd_hi);

  always_comb begin
    out_nxt.status      = status_r;
    out_nxt.front_value = rev_r ? hi_ext : lo_ext;
    out_nxt.back_value  = rev_r ? lo_ext : hi_ext;
    out_nxt.occupancy   = dq_pkg::OCC_W'(cnt_r);
    out_nxt.is_empty    = empty;
    out_nxt.is_full     = full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
      rev_r  <= 1'b0;
    end else if (cmd.exec) begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
      rev_r  <= rev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_data.action;
      val_r <= in_data.value[dq_pkg::WORD_BITS-1:0];
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
    end
    if (cmd.load) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

### rtl/double_ended_queue.sv
// top level of the double-ended queue
// Double-ended queue of up to dq_pkg::DEPTH words in a ring store addressed by
// a head index and a count, with a reversed flag that swaps the two ends. Each
// input word carries one action and produces one result word with status,
// front and back words, occupancy and empty/full flags. Items are handled one
// at a time: an accepted word passes through capture, update and ring write,
// registered ring read of both ends and result load, and a new word is only
// taken once the previous one is loaded. The result register lets the next
// word be accepted while the previous result waits; the ring's one write
// port and registered read ports set this sequence.
module double_ended_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  dq_pkg::dq_in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output dq_pkg::dq_out_t out_data
);

  dq_pkg::dq_cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  dq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

### test/double_ended_queue_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the double-ended queue: directed, random and backpressure traffic
module double_ended_queue_test;

  localparam logic [dq_pkg::ACTION_W-1:0] ACT_RESERVED = 3'd7;
  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  dq_pkg::dq_in_t  in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  dq_pkg::dq_out_t out_data;

  logic [dq_pkg::VALUE_W-1:0] ring_words [dq_pkg::DEPTH];
  logic [dq_pkg::IDX_W-1:0]   head_slot = '0;
  logic [dq_pkg::CNT_W-1:0]   word_count = '0;
  logic                       flipped = 1'b0;

  dq_pkg::dq_out_t deque_snapshots [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int mismatches = 0;
  int words_sent = 0;
  int words_checked = 0;
  int refused_empty = 0;
  int refused_full = 0;
  int full_hits = 0;

  double_ended_queue u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic dq_pkg::dq_out_t apply_action(input dq_pkg::dq_in_t w);
    dq_pkg::dq_out_t            r;
    logic [dq_pkg::IDX_W-1:0]   slot;
    logic                       lo_end;
    logic [dq_pkg::VALUE_W-1:0] kept;
    r = '0;
    r.status = dq_pkg::ST_OK;
    kept = dq_pkg::VALUE_W'(w.value[dq_pkg::WORD_BITS-1:0]);
    case (w.action)
      dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_BACK: begin
        if (word_count == dq_pkg::DEPTH) begin
          r.status = dq_pkg::ST_FULL;
        end else begin
          lo_end = (w.action == dq_pkg::ACT_PUSH_FRONT) ^ flipped;
          if (lo_end) begin
            head_slot = head_slot - 1'b1;
            ring_words[head_slot] = kept;
          end else begin
            slot = head_slot + word_count[dq_pkg::IDX_W-1:0];
            ring_words[slot] = kept;
          end
          word_count = word_count + 1'b1;
        end
      end
      dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_POP_BACK: begin
        if (word_count == 0) begin
          r.status = dq_pkg::ST_EMPTY;
        end else begin
          lo_end = (w.action == dq_pkg::ACT_POP_FRONT) ^ flipped;
          if (lo_end) head_slot = head_slot + 1'b1;
          word_count = word_count - 1'b1;
        end
      end
      dq_pkg::ACT_REVERSE: begin
        if (word_count == 0) r.status = dq_pkg::ST_EMPTY;
        else flipped = ~flipped;
      end
      dq_pkg::ACT_CLEAR: begin
        head_slot = '0;
        word_count = '0;
        flipped = 1'b0;
      end
      default: ;
    endcase
    if (word_count != 0) begin
      slot = head_slot + word_count[dq_pkg::IDX_W-1:0] - 1'b1;
      r.front_value = flipped ? ring_words[slot] : ring_words[head_slot];
      r.back_value  = flipped ? ring_words[head_slot] : ring_words[slot];
    end
    r.occupancy = dq_pkg::OCC_W'(word_count);
    r.is_empty  = (word_count == 0);
    r.is_full   = (word_count == dq_pkg::DEPTH);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= 30)
      $display("mismatch on %s: got %h, want %h (word %0d, %0t)", what, got, want,
               words_checked, $time);
  endtask

  task automatic check_result(input dq_pkg::dq_out_t got);
    dq_pkg::dq_out_t want;
    if (deque_snapshots.size() == 0) begin
      report_mismatch("result with nothing pending", got.occupancy, '0);
    end else begin
      want = deque_snapshots.pop_front();
      words_checked++;
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.front_value !== want.front_value)
        report_mismatch("front_value", got.front_value, want.front_value);
      if (got.back_value !== want.back_value)
        report_mismatch("back_value", got.back_value, want.back_value);
      if (got.occupancy !== want.occupancy)
        report_mismatch("occupancy", got.occupancy, want.occupancy);
      if (got.is_empty !== want.is_empty)
        report_mismatch("is_empty", got.is_empty, want.is_empty);
      if (got.is_full !== want.is_full) report_mismatch("is_full", got.is_full, want.is_full);
      if (want.status == dq_pkg::ST_EMPTY) refused_empty++;
      if (want.status == dq_pkg::ST_FULL) refused_full++;
      if (want.is_full) full_hits++;
    end
  endtask

  // result side: check accepted words, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL double_ended_queue");
    $finish;
  end

  task automatic send_word(input logic [dq_pkg::ACTION_W-1:0] act,
                           input logic [dq_pkg::VALUE_W-1:0] val);
    dq_pkg::dq_in_t w;
    w.action = act;
    w.value  = val;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deque_snapshots.push_back(apply_action(w));
    words_sent++;
  endtask

  function automatic dq_pkg::dq_in_t random_action(input int push_pct);
    dq_pkg::dq_in_t w;
    int             pick;
    pick = $urandom_range(99);
    w.value = {$urandom, $urandom};
    case ($urandom_range(7))
      0: w.value = '0;
      1: w.value = '1;
      default: ;
    endcase
    if (pick < push_pct)
      w.action = $urandom_range(1) ? dq_pkg::ACT_PUSH_FRONT : dq_pkg::ACT_PUSH_BACK;
    else if (pick < 92)
      w.action = $urandom_range(1) ? dq_pkg::ACT_POP_FRONT : dq_pkg::ACT_POP_BACK;
    else if (pick < 96) w.action = dq_pkg::ACT_REVERSE;
    else if (pick < 98) w.action = $urandom_range(1) ? dq_pkg::ACT_NONE : ACT_RESERVED;
    else w.action = dq_pkg::ACT_CLEAR;
    return w;
  endfunction

  task automatic test_empty_refusals();
    send_idle_pct = 6;
    recv_idle_pct = 45;
    send_word(dq_pkg::ACT_POP_FRONT, '1);
    send_word(dq_pkg::ACT_POP_BACK, '0);
    send_word(dq_pkg::ACT_REVERSE, 64'hdead_beef_0123_4567);
    send_word(dq_pkg::ACT_NONE, '1);
    send_word(ACT_RESERVED, {$urandom, $urandom});
  endtask

  task automatic test_basic_ops();
    send_word(dq_pkg::ACT_PUSH_FRONT, '0);
    send_word(dq_pkg::ACT_PUSH_BACK, '1);
    send_word(dq_pkg::ACT_PUSH_FRONT, 64'h5555_5555_5555_5555);
    send_word(dq_pkg::ACT_REVERSE, '0);
    send_word(dq_pkg::ACT_PUSH_BACK, 64'haaaa_aaaa_aaaa_aaaa);
    send_word(dq_pkg::ACT_POP_FRONT, '1);
    send_word(dq_pkg::ACT_POP_BACK, '0);
    send_word(dq_pkg::ACT_REVERSE, '1);
    send_word(dq_pkg::ACT_POP_BACK, '0);
    send_word(dq_pkg::ACT_CLEAR, '1);
    send_word(dq_pkg::ACT_POP_FRONT, '0);
  endtask

  // fill to capacity, refuse at both ends, then drain and refill across the wrap
  task automatic test_fill_and_wrap();
    send_word(dq_pkg::ACT_CLEAR, '0);
    for (int i = 0; i < dq_pkg::DEPTH; i++)
      send_word(i[0] ? dq_pkg::ACT_PUSH_BACK : dq_pkg::ACT_PUSH_FRONT, {$urandom, $urandom});
    send_word(dq_pkg::ACT_PUSH_FRONT, '1);
    send_word(dq_pkg::ACT_PUSH_BACK, '0);
    send_word(dq_pkg::ACT_REVERSE, '0);
    send_word(dq_pkg::ACT_POP_FRONT, '0);
    send_word(dq_pkg::ACT_POP_FRONT, '0);
    send_word(dq_pkg::ACT_POP_BACK, '0);
    send_word(dq_pkg::ACT_PUSH_BACK, {$urandom, $urandom});
    send_word(dq_pkg::ACT_PUSH_FRONT, {$urandom, $urandom});
    send_word(dq_pkg::ACT_PUSH_BACK, {$urandom, $urandom});
  endtask

  task automatic test_random_traffic(input int items, input int s_pct, input int r_pct);
    dq_pkg::dq_in_t w;
    int             bias;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    bias = 50;
    for (int i = 0; i < items; i++) begin
      // bursts that lean toward filling, draining or neither
      if (i % 24 == 0) bias = 20 + 30 * $urandom_range(2);
      w = random_action(bias);
      send_word(w.action, w.value);
    end
  endtask

  task automatic test_backpressure();
    dq_pkg::dq_in_t w;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) begin
      w = random_action(80);
      send_word(w.action, w.value);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_refusals();
    test_basic_ops();
    test_fill_and_wrap();
    test_random_traffic(400, 6, 45);
    test_random_traffic(400, 45, 6);
    test_random_traffic(400, 0, 0);
    test_backpressure();
    in_valid <= 1'b0;
    while (deque_snapshots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d actions, checked %0d results; %0d refused as empty, %0d as full",
             words_sent, words_checked, refused_empty, refused_full);
    $display("queue reported full %0d times; one result stall of %0d cycles",
             full_hits, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("PASS double_ended_queue");
    end else begin
      $display("FAIL double_ended_queue");
    end
    $finish;
  end

endmodule
